// ----- hdl/rpbu_pkg.sv -----
// Shared types and codes for the RGB pixel blend unit.
// No dependencies; every other file in hdl/ depends on this package.
package rpbu_pkg;

  localparam int CHAN_W    = 8;
  localparam int OP_W      = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 8;

  // Operation codes
  localparam logic [OP_W-1:0] OP_MULTIPLY  = 3'd0;
  localparam logic [OP_W-1:0] OP_SUBTRACT  = 3'd1;
  localparam logic [OP_W-1:0] OP_SCREEN    = 3'd2;
  localparam logic [OP_W-1:0] OP_OVERLAY   = 3'd3;
  localparam logic [OP_W-1:0] OP_ADD_GREEN = 3'd4;
  localparam logic [OP_W-1:0] OP_SCALE_RED = 3'd5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GREEN_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RED_SCALE    = 2'd1;

  localparam logic [CHAN_W-1:0] GREEN_OFFSET_RST = 8'd0;
  localparam logic [CHAN_W-1:0] RED_SCALE_RST    = 8'd1;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [CHAN_W-1:0] top_red;
    logic [CHAN_W-1:0] top_green;
    logic [CHAN_W-1:0] top_blue;
    logic [CHAN_W-1:0] bottom_red;
    logic [CHAN_W-1:0] bottom_green;
    logic [CHAN_W-1:0] bottom_blue;
  } in_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_red;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_blue;
  } out_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0] green_offset;
    logic [CHAN_W-1:0] red_scale;
  } cfg_t;

endpackage

// ----- hdl/rgb_pixel_blend_unit_core.sv -----
// Top level of the RGB pixel blend unit: input register, pixel math, result register.
// Depends on rpbu_pkg, rpbu_cfg_regs and rpbu_pixel_math.
//
//   port group | direction | flow control      | payload
//   -----------+-----------+-------------------+-------------------------------
//   in_*       | in        | in_valid/in_stall | op, top and bottom RGB pixel
//   out_*      | out       | out_valid/out_stall| blended RGB pixel
//   cfg_*      | in        | cfg_we only       | green_offset, red_scale
//
// One transaction per clock sustained while out_stall is low; an accepted transaction
// passes the input register, then the result register, before out_valid rises.
// The blend math between the two registers is one 8x8 multiply per channel plus a
// constant-reciprocal divide by 255 with a single correction step.
// rst_n is synchronous: clears both valid flags and loads register defaults.
// out_stall backs up into in_stall only when both registers hold transactions.
module rgb_pixel_blend_unit_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  rpbu_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output rpbu_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [rpbu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rpbu_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import rpbu_pkg::*;

  cfg_t      cfg;
  in_item_t  s1_data_r;
  logic      s1_valid_r;
  out_item_t out_data_r;
  logic      out_valid_r;
  out_item_t result;
  logic      out_adv;

  rpbu_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Result register can take a new value when empty or being drained.
  assign out_adv  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !out_adv;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data_r <= in_data;
    end
  end

  rpbu_pixel_math u_math (
    .item (s1_data_r),
    .cfg  (cfg),
    .res  (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s1_valid_r) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- hdl/rpbu_cfg_regs.sv -----
// Configuration registers of the blend unit (green offset, red scale).
// Depends on rpbu_pkg.
module rpbu_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [rpbu_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rpbu_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output rpbu_pkg::cfg_t                    cfg
);
  import rpbu_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.green_offset <= GREEN_OFFSET_RST;
      cfg_r.red_scale    <= RED_SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GREEN_OFFSET: cfg_r.green_offset <= cfg_wdata;
        CFG_RED_SCALE:    cfg_r.red_scale    <= cfg_wdata;
        default: ;  // index outside the map: write dropped
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- hdl/rpbu_channel.sv -----
// One color channel of the blend: multiply, subtract, screen and overlay.
// Depends on rpbu_pkg.
module rpbu_channel (
  input  logic [rpbu_pkg::OP_W-1:0]   op,
  input  logic [rpbu_pkg::CHAN_W-1:0] a,
  input  logic [rpbu_pkg::CHAN_W-1:0] b,
  output logic [rpbu_pkg::CHAN_W-1:0] res
);
  import rpbu_pkg::*;

  logic              use_inv;
  logic              dbl;
  logic [CHAN_W-1:0] x;
  logic [CHAN_W-1:0] y;
  logic [15:0]       prod;
  logic [16:0]       p;
  logic [16:0]       t;
  logic [24:0]       tw;
  logic [7:0]        est;
  logic [16:0]       est255;
  logic [16:0]       rem;
  logic [7:0]        quo;
  logic [7:0]        mix;
  logic [7:0]        diff;

  // Screen form works on complements: 255 - v == ~v for 8-bit v.
  assign use_inv = (op == OP_SCREEN) || ((op == OP_OVERLAY) && b[7]);
  assign dbl     = (op == OP_OVERLAY);
  assign x       = use_inv ? ~a : a;
  assign y       = use_inv ? ~b : b;
  assign prod    = x * y;
  assign p       = dbl ? {prod, 1'b0} : {1'b0, prod};

  // round(p/255) = floor((p+127)/255); estimate via *257>>16, then one fixup
  assign t      = p + 17'd127;
  assign tw     = {t, 8'd0} + {8'd0, t};
  assign est    = tw[23:16];
  assign est255 = {1'b0, est, 8'd0} - {9'd0, est};
  assign rem    = t - est255;
  assign quo    = (rem >= 17'd255) ? est + 8'd1 : est;
  assign mix    = use_inv ? ~quo : quo;

  assign diff = (a > b) ? 8'd0 : b - a;

  always_comb begin
    case (op)
      OP_SUBTRACT: res = diff;
      default:     res = mix;
    endcase
  end

endmodule

// ----- hdl/rpbu_pixel_math.sv -----
// Per-pixel result: three blend channels plus the add-green and scale-red modes.
// Depends on rpbu_pkg and rpbu_channel.
module rpbu_pixel_math (
  input  rpbu_pkg::in_item_t  item,
  input  rpbu_pkg::cfg_t      cfg,
  output rpbu_pkg::out_item_t res
);
  import rpbu_pkg::*;

  logic [CHAN_W-1:0] blend_r;
  logic [CHAN_W-1:0] blend_g;
  logic [CHAN_W-1:0] blend_b;
  logic [CHAN_W:0]   gsum;
  logic [CHAN_W-1:0] gsat;
  logic [2*CHAN_W-1:0] rprod;
  logic [CHAN_W-1:0] rsat;

  rpbu_channel u_ch_red (
    .op (item.op), .a (item.top_red),   .b (item.bottom_red),   .res (blend_r)
  );
  rpbu_channel u_ch_green (
    .op (item.op), .a (item.top_green), .b (item.bottom_green), .res (blend_g)
  );
  rpbu_channel u_ch_blue (
    .op (item.op), .a (item.top_blue),  .b (item.bottom_blue),  .res (blend_b)
  );

  assign gsum  = {1'b0, item.top_green} + {1'b0, cfg.green_offset};
  assign gsat  = gsum[CHAN_W] ? '1 : gsum[CHAN_W-1:0];
  assign rprod = item.top_red * cfg.red_scale;
  assign rsat  = (|rprod[2*CHAN_W-1:CHAN_W]) ? '1 : rprod[CHAN_W-1:0];

  always_comb begin
    case (item.op) inside
      OP_MULTIPLY, OP_SUBTRACT, OP_SCREEN, OP_OVERLAY: begin
        res.out_red   = blend_r;
        res.out_green = blend_g;
        res.out_blue  = blend_b;
      end
      OP_ADD_GREEN: begin
        res.out_red   = item.top_red;
        res.out_green = gsat;
        res.out_blue  = item.top_blue;
      end
      OP_SCALE_RED: begin
        res.out_red   = rsat;
        res.out_green = item.top_green;
        res.out_blue  = '0;
      end
      default: begin
        res = '0;  // unused op codes
      end
    endcase
  end

endmodule

// ----- hdl/rpbu_checker.sv -----
// Port-level checks for rgb_pixel_blend_unit_core, attached by bind.
// Depends on rpbu_pkg and the top level's port list.
module rpbu_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input rpbu_pkg::out_item_t  out_data
);

  // Held result must not move while stalled.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Input backs up only when a result is blocked downstream.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // Accepted transaction passes both registers to out_valid if output is not blocked.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) ##1 !out_stall |=> out_valid)
    else $error("accepted transaction did not reach the output");

  // Reset empties the pipeline.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

endmodule

bind rgb_pixel_blend_unit_core rpbu_checker u_rpbu_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ----- bench/tb.sv -----
// Self-checking bench for rgb_pixel_blend_unit_core: directed pixel table, then random phases.
// Depends on rpbu_pkg and the RTL under hdl/; expected: in-bench predictor or hand-typed rows.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rpbu_pkg::*;

  // Op codes the block leaves unused; they must blend to black.
  localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;
  // Register indexes past the map; writes to them must be dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_3 = 2'd3;

  localparam int N_PHASES        = 6;
  localparam int ITEMS_PER_PHASE = 308;
  localparam int HOLD_AT_ITEM    = 150;     // sender holds off here until drained
  localparam int DRAIN_CYCLES    = 8;       // two-stage pipe plus margin
  localparam int CYCLE_LIMIT     = 200000;  // watchdog bound on the whole run

  typedef struct {
    in_item_t  px;
    bit        typed;   // want holds a hand-written result
    out_item_t want;
  } pixel_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Bench copy of the two registers, updated when a write is issued.
  logic [CHAN_W-1:0] green_offset_q = GREEN_OFFSET_RST;
  logic [CHAN_W-1:0] red_scale_q    = RED_SCALE_RST;

  out_item_t  blended_due[$];   // expected pixels, oldest first
  pixel_row_t pixel_table[$];
  int         in_idle_pct  = 0;
  int         out_idle_pct = 0;
  int         err_count    = 0;
  int         cycle_count  = 0;

  rgb_pixel_blend_unit_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Watchdog: a hung handshake or a lost pixel ends here.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // One channel of the two-pixel modes. 255 is odd, so rounding never ties.
  function automatic logic [CHAN_W-1:0] blend_chan(logic [OP_W-1:0] op,
                                                   logic [CHAN_W-1:0] a,
                                                   logic [CHAN_W-1:0] b);
    int unsigned x, y, q, r;
    x = a;
    y = b;
    q = (255 - x) * (255 - y);
    case (op)
      OP_MULTIPLY: r = (2 * x * y + 255) / 510;
      OP_SUBTRACT: r = (x > y) ? 0 : y - x;
      OP_SCREEN:   r = 255 - (2 * q + 255) / 510;
      default:     r = (y <= 127) ? (4 * x * y + 255) / 510 : 255 - (4 * q + 255) / 510;
    endcase
    return r[CHAN_W-1:0];
  endfunction

  function automatic out_item_t blend_pixel(in_item_t px);
    out_item_t   res;
    int unsigned sum;
    res = '0;
    case (px.op)
      OP_MULTIPLY, OP_SUBTRACT, OP_SCREEN, OP_OVERLAY: begin
        res.out_red   = blend_chan(px.op, px.top_red,   px.bottom_red);
        res.out_green = blend_chan(px.op, px.top_green, px.bottom_green);
        res.out_blue  = blend_chan(px.op, px.top_blue,  px.bottom_blue);
      end
      OP_ADD_GREEN: begin
        sum           = px.top_green + green_offset_q;
        res.out_red   = px.top_red;
        res.out_green = (sum > 255) ? 8'd255 : sum[CHAN_W-1:0];
        res.out_blue  = px.top_blue;
      end
      OP_SCALE_RED: begin
        sum           = px.top_red * red_scale_q;
        res.out_red   = (sum > 255) ? 8'd255 : sum[CHAN_W-1:0];
        res.out_green = px.top_green;
        res.out_blue  = '0;     // blue is forced to zero in this mode
      end
      default: res = '0;        // unused op codes give black
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  // Sampled at the edge, so values are the ones settled before it.
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (blended_due.size() == 0) begin
        report_mismatch($sformatf("pixel %h arrived with none pending", out_data));
      end else begin
        want = blended_due.pop_front();
        if (out_data.out_red !== want.out_red)
          report_mismatch($sformatf("red got %0d want %0d", out_data.out_red, want.out_red));
        if (out_data.out_green !== want.out_green)
          report_mismatch($sformatf("green got %0d want %0d",
                                    out_data.out_green, want.out_green));
        if (out_data.out_blue !== want.out_blue)
          report_mismatch($sformatf("blue got %0d want %0d",
                                    out_data.out_blue, want.out_blue));
      end
    end
  end

  // Receiver back-pressure, rolled fresh each cycle.
  always @(posedge clk) out_stall <= ($urandom_range(0, 99) < out_idle_pct);

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  task automatic add_row(logic [OP_W-1:0] op, int tr, int tg, int tb,
                         int br, int bg, int bb, bit typed,
                         int er = 0, int eg = 0, int eb = 0);
    pixel_row_t row;
    row.px    = '{op, tr[7:0], tg[7:0], tb[7:0], br[7:0], bg[7:0], bb[7:0]};
    row.typed = typed;
    row.want  = '{er[7:0], eg[7:0], eb[7:0]};
    pixel_table = {pixel_table, row};
  endtask

  function automatic logic [CHAN_W-1:0] rand_chan();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 8)  return 8'd0;
    if (roll < 16) return 8'd255;
    if (roll < 22) return 8'd127 + roll[0];   // overlay split point
    return 8'($urandom);
  endfunction

  function automatic in_item_t rand_pixel();
    in_item_t    px;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 6) px.op = roll[0] ? OP_RSVD_7 : OP_RSVD_6;
    else          px.op = 3'($urandom_range(0, 5));
    px.top_red      = rand_chan();
    px.top_green    = rand_chan();
    px.top_blue     = rand_chan();
    px.bottom_red   = rand_chan();
    px.bottom_green = rand_chan();
    px.bottom_blue  = rand_chan();
    return px;
  endfunction

  // Present one transaction and hold it until accepted. Idle gaps go in
  // front, so valid never reacts to stall. Returns on the accepting edge.
  task automatic send_pixel(in_item_t px, bit typed, out_item_t want);
    out_item_t due;
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    due = typed ? want : blend_pixel(px);
    blended_due = {blended_due, due};
  endtask

  // Drop valid and wait until every pending pixel has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (blended_due.size() != 0);
  endtask

  // Registers are only touched with the pipe empty; the bench copy
  // changes along with the write.
  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_GREEN_OFFSET: green_offset_q = val;
      CFG_RED_SCALE:    red_scale_q    = val;
      default: ;        // unmapped index, ignored
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin : main_seq
    int gofs, scl;

    // Directed rows run with reset register values (offset 0, scale 1).
    // Hand-written results are the easy ones: extremes, passthrough, black.
    //      op            top rgb        bottom rgb     typed  want rgb
    add_row(OP_MULTIPLY,  255,   0, 255, 255, 255,   0, 1,   255,   0,   0);
    add_row(OP_MULTIPLY,    0,   0,   0,   0,   0,   0, 1,     0,   0,   0);
    add_row(OP_MULTIPLY,  128, 200,  17, 128, 100, 240, 0);
    // subtract clamps at zero when top exceeds bottom
    add_row(OP_SUBTRACT,    0, 255, 200, 255,   0, 200, 1,   255,   0,   0);
    add_row(OP_SUBTRACT,   37, 180,  99, 201,  12,  99, 0);
    add_row(OP_SCREEN,      0, 255,   0,   0,   0, 255, 1,     0, 255, 255);
    add_row(OP_SCREEN,    255, 255, 255, 255, 255, 255, 1,   255, 255, 255);
    add_row(OP_SCREEN,     64, 128, 191,  77,  33, 250, 0);
    // overlay switches form between bottom 127 and 128
    add_row(OP_OVERLAY,   255,   0, 255, 127, 128, 255, 1,   254,   1, 255);
    add_row(OP_OVERLAY,     0, 255, 128,   0,   0, 200, 0);
    add_row(OP_OVERLAY,   100, 128, 200, 127, 128, 129, 0);
    add_row(OP_OVERLAY,   255, 255,   1, 126, 128,  60, 0);
    // single-pixel modes ignore the bottom pixel
    add_row(OP_ADD_GREEN, 255, 255,   0,   1,   2,   3, 1,   255, 255,   0);
    add_row(OP_ADD_GREEN,   0,   0, 255, 255, 255, 255, 1,     0,   0, 255);
    add_row(OP_SCALE_RED, 255, 128, 255,  10,  20,  30, 1,   255, 128,   0);
    add_row(OP_SCALE_RED,   0,   0,   0, 255, 255, 255, 1,     0,   0,   0);
    add_row(OP_RSVD_6,    255, 255, 255, 255, 255, 255, 1,     0,   0,   0);
    add_row(OP_RSVD_7,     90, 180,  45, 200,  10, 250, 1,     0,   0,   0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (pixel_table[i])
      send_pixel(pixel_table[i].px, pixel_table[i].typed, pixel_table[i].want);
    drain_results();

    // Random phases: register extremes first, then random values (phase 3: offset 1, scale 2).
    // Idling: sender 25%/receiver 76%, then swapped, then none.
    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: begin gofs = 255; scl = 0;   end
        1: begin gofs = 0;   scl = 255; end
        3: begin gofs = 1;   scl = 2;   end
        default: begin
          gofs = $urandom_range(0, 255);
          scl  = $urandom_range(0, 255);
        end
      endcase
      in_idle_pct  = (ph < 2) ? 25 : (ph < 4) ? 76 : 0;
      out_idle_pct = (ph < 2) ? 76 : (ph < 4) ? 25 : 0;

      write_cfg(CFG_GREEN_OFFSET, gofs[7:0]);
      write_cfg(CFG_RED_SCALE, scl[7:0]);
      if (ph == 2) begin
        // writes past the map must leave both registers alone
        write_cfg(CFG_UNMAPPED_2, 8'($urandom));
        write_cfg(CFG_UNMAPPED_3, 8'($urandom));
      end

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (ph == 1 && n == HOLD_AT_ITEM) drain_results();
        send_pixel(rand_pixel(), 1'b0, '0);
      end
      drain_results();
    end

    out_idle_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);   // catch stray extra results

    if (err_count == 0) $display("end of test: clean");
    else                $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/rpbu_pkg.sv
hdl/rpbu_cfg_regs.sv
hdl/rpbu_channel.sv
hdl/rpbu_pixel_math.sv
hdl/rgb_pixel_blend_unit_core.sv
hdl/rpbu_checker.sv
bench/tb.sv
